// ===== sv/cirp92_pkg.sv =====
// Shared types and constants for the indexed chipset register block.
// Used by the top level; no dependencies.
package cirp92_pkg;

    localparam logic [15:0] PortIndex = 16'h00F2;
    localparam logic [15:0] PortData  = 16'h00F3;
    localparam logic [15:0] PortPost  = 16'h0078;
    localparam logic [15:0] PortFast  = 16'h0092;

    localparam logic [7:0] ShadowReg   = 8'h02;
    localparam logic [7:0] Port92Fill  = 8'hFC;

    localparam logic OpRead  = 1'b0;
    localparam logic OpWrite = 1'b1;

    typedef struct packed {
        logic [7:0]  write_data;
        logic [15:0] port_address;
        logic        operation;
    } item_t;

    typedef struct packed {
        logic       soft_reset;
        logic       a20_changed;
        logic       a20_gate;
        logic       e_seg_write_internal;
        logic       e_seg_read_internal;
        logic       f_seg_write_internal;
        logic       f_seg_read_internal;
        logic [7:0] read_data;
        logic       claimed;
    } result_t;

    typedef struct packed {
        logic is_index;
        logic is_data;
        logic is_post;
        logic is_fast;
    } port_dec_t;

    function automatic port_dec_t decode_port(input logic [15:0] addr);
        port_dec_t d;
        d.is_index = (addr == PortIndex);
        d.is_data  = (addr == PortData);
        d.is_post  = (addr == PortPost);
        d.is_fast  = (addr == PortFast);
        return d;
    endfunction

endpackage

// ===== sv/cirp92_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cirp92_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/chipset_index_regs_shadow_port92_top.sv =====
// Indexed chipset registers (ports F2h/F3h), POST port 78h and port 92h fast A20 latch.
// Depends on cirp92_pkg and cirp92_ram.
//
// One I/O access per item, one item accepted every cycle unless the output stalls.
// An accepted item sits in the work stage while the register file RAM delivers its
// registered read, then its result lands in the output register and m_tvalid rises;
// a stalled output holds the item in the work stage and stops new items.
// Reads of the register file return zero for entries never written since reset
// (per-entry valid flops), so no clearing pass is needed after reset. Shadow control
// outputs come from a flop copy of register 2.
module chipset_index_regs_shadow_port92_top #(
    parameter int REG_COUNT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // port_address[15:0], write_data[23:16]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // claimed, read_data[8:1], f_seg_read_internal,
                                   // f_seg_write_internal, e_seg_read_internal,
                                   // e_seg_write_internal, a20_gate, a20_changed,
                                   // soft_reset
);

    localparam int AW = $clog2(REG_COUNT);
    localparam logic [8:0] RegCountW = 9'(REG_COUNT);

    cirp92_pkg::item_t     item_reg;
    logic                  s1_valid_reg;
    cirp92_pkg::result_t   res_reg, res_next;
    logic                  m_valid_reg;

    logic [7:0]            index_reg, index_next;
    logic [7:0]            shadow_reg, shadow_next;
    logic [7:0]            latch_reg, latch_next;
    logic                  a20_reg, a20_next;
    logic [REG_COUNT-1:0]  valid_reg;
    logic                  rdv_reg;
    logic                  fwd_reg;
    logic [7:0]            fwd_data_reg;

    logic                  accept, advance;
    logic                  ram_we;
    logic [AW-1:0]         waddr, raddr;
    logic [7:0]            ram_q;
    logic                  fwd_next;
    logic                  in_range;
    logic [7:0]            file_byte;
    logic                  is_wr;
    cirp92_pkg::port_dec_t dec;

    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign dec      = cirp92_pkg::decode_port(item_reg.port_address);
    assign is_wr    = (item_reg.operation == cirp92_pkg::OpWrite);
    assign in_range = ({1'b0, index_reg} < RegCountW);
    assign waddr    = index_reg[AW-1:0];
    assign raddr    = index_next[AW-1:0];
    assign ram_we   = advance && is_wr && dec.is_data && in_range;
    assign fwd_next = ram_we && (waddr == raddr);

    assign file_byte = !in_range ? 8'h00 :
                       fwd_reg   ? fwd_data_reg :
                       rdv_reg   ? ram_q : 8'h00;

    cirp92_ram #(
        .WIDTH (8),
        .DEPTH (REG_COUNT)
    ) u_regfile (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (item_reg.write_data),
        .re    (accept),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_comb begin
        index_next  = index_reg;
        shadow_next = shadow_reg;
        latch_next  = latch_reg;
        a20_next    = a20_reg;
        res_next    = '0;
        if (advance) begin
            if (dec.is_index) begin
                res_next.claimed = 1'b1;
                if (is_wr) begin
                    index_next = item_reg.write_data;
                end else begin
                    res_next.read_data = index_reg;
                end
            end else if (dec.is_data) begin
                res_next.claimed = 1'b1;
                if (is_wr) begin
                    if (index_reg == cirp92_pkg::ShadowReg) begin
                        shadow_next = item_reg.write_data;
                    end
                end else begin
                    res_next.read_data = file_byte;
                end
            end else if (dec.is_post) begin
                res_next.claimed = 1'b1;
            end else if (dec.is_fast) begin
                res_next.claimed = 1'b1;
                if (is_wr) begin
                    a20_next = item_reg.write_data[1];
                    res_next.a20_changed = (item_reg.write_data[1] != a20_reg);
                    res_next.soft_reset  = ~latch_reg[0] & item_reg.write_data[0];
                    latch_next = item_reg.write_data | cirp92_pkg::Port92Fill;
                end else begin
                    res_next.read_data = latch_reg | cirp92_pkg::Port92Fill;
                end
            end
        end
        res_next.f_seg_read_internal  = shadow_next[3] & shadow_next[4];
        res_next.f_seg_write_internal = shadow_next[3] & ~shadow_next[5];
        res_next.e_seg_read_internal  = shadow_next[2] & shadow_next[4];
        res_next.e_seg_write_internal = shadow_next[2] & ~shadow_next[5];
        res_next.a20_gate             = a20_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            index_reg    <= '0;
            shadow_reg   <= '0;
            latch_reg    <= '0;
            a20_reg      <= 1'b0;
            valid_reg    <= '0;
            rdv_reg      <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            index_reg  <= index_next;
            shadow_reg <= shadow_next;
            latch_reg  <= latch_next;
            a20_reg    <= a20_next;
            if (ram_we) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
                rdv_reg      <= valid_reg[raddr];
                fwd_reg      <= fwd_next;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.operation    <= s_tuser;
            item_reg.port_address <= s_tdata[15:0];
            item_reg.write_data   <= s_tdata[23:16];
            fwd_data_reg          <= item_reg.write_data;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg;

    // latch is either untouched or has its upper bits forced high
    a_latch_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (latch_reg == 8'h00) || (&latch_reg[7:2]))
        else $error("port 92 latch upper bits not set");

    // forwarding only follows a RAM write seen at an accept edge
    a_fwd_src: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg && !$stable(fwd_reg) |-> $past(accept) && $past(ram_we))
        else $error("forward flag without write");

    a_rdata_claimed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (res_reg.read_data != 8'h00) |-> res_reg.claimed)
        else $error("read data on unclaimed port");

    a_sreset_claimed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (res_reg.soft_reset || res_reg.a20_changed) |-> res_reg.claimed)
        else $error("port 92 event on unclaimed access");

endmodule

// ===== sim/chipset_index_regs_shadow_port92_top_tb.sv =====
// Self-checking testbench for chipset_index_regs_shadow_port92_top: a directed table,
// then weighted random I/O accesses, with bursty input and stalling output.
// Depends on cirp92_pkg and the RTL of the top level.
`timescale 1ns / 1ps

module chipset_index_regs_shadow_port92_top_tb;

    localparam int RegCount   = 256;
    localparam int RandItems  = 700;
    localparam int CycleLimit = 200000;
    localparam int DrainWait  = 8;

    typedef struct packed {
        logic                has_exp;
        cirp92_pkg::item_t   acc;
        cirp92_pkg::result_t exp;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // port_address[15:0], write_data[23:16]
    logic        s_tuser = 1'b0; // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // claimed, read_data[8:1], f_seg_read_internal,
                                 // f_seg_write_internal, e_seg_read_internal,
                                 // e_seg_write_internal, a20_gate, a20_changed, soft_reset

    chipset_index_regs_shadow_port92_top #(.REG_COUNT(RegCount)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mirror of the block state
    logic [7:0] mirror_regs [RegCount];
    logic [7:0] mirror_index;
    logic [7:0] mirror_latch;
    logic       mirror_a20;

    stim_row_t           access_q [$];
    cirp92_pkg::result_t pending_results [$];
    stim_row_t           cur_row;
    int        next_idx = 0;
    int        accepted = 0;
    int        errors = 0;
    int        cycles = 0;
    int        burst_left = 1;
    int        gap_left = 0;
    int        rx_mode = 0;
    logic [15:0] rx_pat = 16'hB6D3;

    function automatic cirp92_pkg::result_t model_access(cirp92_pkg::item_t a);
        cirp92_pkg::result_t r;
        logic [7:0]          r2;
        logic                new_a20;
        r = '0;
        if (a.port_address == cirp92_pkg::PortIndex) begin
            r.claimed = 1'b1;
            if (a.operation == cirp92_pkg::OpWrite) mirror_index = a.write_data;
            else r.read_data = mirror_index;
        end else if (a.port_address == cirp92_pkg::PortData) begin
            r.claimed = 1'b1;
            if (a.operation == cirp92_pkg::OpWrite) begin
                if (int'(mirror_index) < RegCount) mirror_regs[mirror_index] = a.write_data;
            end else if (int'(mirror_index) < RegCount) begin
                r.read_data = mirror_regs[mirror_index];
            end
        end else if (a.port_address == cirp92_pkg::PortPost) begin
            r.claimed = 1'b1;
        end else if (a.port_address == cirp92_pkg::PortFast) begin
            r.claimed = 1'b1;
            if (a.operation == cirp92_pkg::OpWrite) begin
                new_a20 = a.write_data[1];
                if (new_a20 != mirror_a20) begin
                    mirror_a20 = new_a20;
                    r.a20_changed = 1'b1;
                end
                r.soft_reset = !mirror_latch[0] && a.write_data[0];
                mirror_latch = a.write_data | cirp92_pkg::Port92Fill;
            end else begin
                r.read_data = mirror_latch | cirp92_pkg::Port92Fill;
            end
        end
        r2 = mirror_regs[cirp92_pkg::ShadowReg];
        if (r2[3]) begin
            r.f_seg_read_internal  = r2[4];
            r.f_seg_write_internal = !r2[5];
        end
        if (r2[2]) begin
            r.e_seg_read_internal  = r2[4];
            r.e_seg_write_internal = !r2[5];
        end
        r.a20_gate = mirror_a20;
        return r;
    endfunction

    function automatic cirp92_pkg::result_t plain_result(logic claimed, logic [7:0] rdata);
        cirp92_pkg::result_t r;
        r = '0;
        r.claimed   = claimed;
        r.read_data = rdata;
        return r;
    endfunction

    task automatic add_row(logic op, logic [15:0] addr, logic [7:0] data,
                           logic has_exp, cirp92_pkg::result_t exp);
        stim_row_t row;
        row.has_exp          = has_exp;
        row.acc.operation    = op;
        row.acc.port_address = addr;
        row.acc.write_data   = data;
        row.exp              = exp;
        access_q.push_back(row);
    endtask

    task automatic add_random_row();
        int          pick;
        logic        op;
        logic [15:0] addr;
        logic [7:0]  data;
        pick = $urandom_range(0, 99);
        op   = 1'($urandom_range(0, 1));
        data = 8'($urandom_range(0, 255));
        if (pick < 20) begin
            op   = cirp92_pkg::OpWrite;
            addr = cirp92_pkg::PortIndex;
            if ($urandom_range(0, 9) < 4) data = cirp92_pkg::ShadowReg;
        end else if (pick < 45) begin
            op   = cirp92_pkg::OpWrite;
            addr = cirp92_pkg::PortData;
        end else if (pick < 63) begin
            op   = cirp92_pkg::OpRead;
            addr = cirp92_pkg::PortData;
        end else if (pick < 70) begin
            op   = cirp92_pkg::OpRead;
            addr = cirp92_pkg::PortIndex;
        end else if (pick < 80) begin
            op   = cirp92_pkg::OpWrite;
            addr = cirp92_pkg::PortFast;
        end else if (pick < 85) begin
            op   = cirp92_pkg::OpRead;
            addr = cirp92_pkg::PortFast;
        end else if (pick < 89) begin
            addr = cirp92_pkg::PortPost;
        end else if (pick < 94) begin
            case ($urandom_range(0, 3))
                0: addr = cirp92_pkg::PortIndex;
                1: addr = cirp92_pkg::PortData;
                2: addr = cirp92_pkg::PortPost;
                default: addr = cirp92_pkg::PortFast;
            endcase
            addr = addr ^ (16'h1 << $urandom_range(0, 15));
        end else begin
            addr = 16'($urandom_range(0, 65535));
        end
        add_row(op, addr, data, 1'b0, '0);
    endtask

    // stimulus, prediction and checking
    always @(posedge aclk) begin
        cirp92_pkg::result_t got;
        cirp92_pkg::result_t exp_r;
        cirp92_pkg::result_t pred;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            m_tready   <= 1'b0;
            burst_left <= 1;
            gap_left   <= 0;
        end else begin
            cycles <= cycles + 1;
            if (cycles > CycleLimit) begin
                $display("chipset_index_regs_shadow_port92_top verification failed");
                $finish;
            end else begin
                if (s_tvalid && s_tready) begin
                    pred = model_access(cur_row.acc);
                    pending_results.push_back(cur_row.has_exp ? cur_row.exp : pred);
                    accepted++;
                end
                if (m_tvalid && m_tready) begin
                    got = cirp92_pkg::result_t'(m_tdata);
                    if (pending_results.size() == 0) begin
                        $display("%0t: unexpected result, expected none, got %04h",
                                 $time, m_tdata);
                        errors++;
                    end else begin
                        exp_r = pending_results.pop_front();
                        if (got !== exp_r) begin
                            $display("%0t: result mismatch, expected %04h, got %04h",
                                     $time, exp_r, got);
                            errors++;
                        end
                    end
                end

                if (!s_tvalid || s_tready) begin
                    if (gap_left > 0) begin
                        gap_left <= gap_left - 1;
                        s_tvalid <= 1'b0;
                    end else if (next_idx < access_q.size()) begin
                        cur_row  <= access_q[next_idx];
                        s_tvalid <= 1'b1;
                        s_tuser  <= access_q[next_idx].acc.operation;
                        s_tdata  <= {access_q[next_idx].acc.write_data,
                                     access_q[next_idx].acc.port_address};
                        next_idx <= next_idx + 1;
                        if (burst_left <= 1) begin
                            burst_left <= $urandom_range(1, 20);
                            gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                        end else begin
                            burst_left <= burst_left - 1;
                        end
                    end else begin
                        s_tvalid <= 1'b0;
                    end
                end

                // receiver: always ready, rotating stall pattern, or random stalls
                if (cycles % 128 == 0) rx_mode <= $urandom_range(0, 2);
                rx_pat <= {rx_pat[14:0], rx_pat[15]};
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= rx_pat[0];
                    default: m_tready <= ($urandom_range(0, 9) < 6);
                endcase
            end
        end
    end

    initial begin
        for (int i = 0; i < RegCount; i++) mirror_regs[i] = '0;
        mirror_index = '0;
        mirror_latch = '0;
        mirror_a20   = 1'b0;

        add_row(cirp92_pkg::OpRead,  cirp92_pkg::PortIndex, 8'h00, 1'b1,
                plain_result(1'b1, 8'h00));
        add_row(cirp92_pkg::OpRead,  cirp92_pkg::PortData,  8'hFF, 1'b1,
                plain_result(1'b1, 8'h00));
        add_row(cirp92_pkg::OpRead,  cirp92_pkg::PortPost,  8'h00, 1'b1,
                plain_result(1'b1, 8'h00));
        add_row(cirp92_pkg::OpRead,  cirp92_pkg::PortFast,  8'h00, 1'b1,
                plain_result(1'b1, cirp92_pkg::Port92Fill));
        add_row(cirp92_pkg::OpRead,  16'hFFFF, 8'hFF, 1'b1, plain_result(1'b0, 8'h00));
        add_row(cirp92_pkg::OpWrite, 16'h0000, 8'hFF, 1'b1, plain_result(1'b0, 8'h00));
        add_row(cirp92_pkg::OpWrite, cirp92_pkg::PortPost,  8'hFF, 1'b1,
                plain_result(1'b1, 8'h00));
        add_row(cirp92_pkg::OpWrite, cirp92_pkg::PortIndex, cirp92_pkg::ShadowReg, 1'b1,
                plain_result(1'b1, 8'h00));
        add_row(cirp92_pkg::OpWrite, cirp92_pkg::PortData,  8'h3C, 1'b0, '0);
        add_row(cirp92_pkg::OpRead,  cirp92_pkg::PortData,  8'h00, 1'b0, '0);
        add_row(cirp92_pkg::OpWrite, cirp92_pkg::PortData,  8'h08, 1'b0, '0);
        add_row(cirp92_pkg::OpWrite, cirp92_pkg::PortData,  8'h14, 1'b0, '0);
        add_row(cirp92_pkg::OpWrite, cirp92_pkg::PortData,  8'h2C, 1'b0, '0);
        add_row(cirp92_pkg::OpWrite, cirp92_pkg::PortFast,  8'h03, 1'b0, '0);
        add_row(cirp92_pkg::OpRead,  cirp92_pkg::PortFast,  8'h00, 1'b0, '0);
        add_row(cirp92_pkg::OpWrite, cirp92_pkg::PortFast,  8'h01, 1'b0, '0);
        add_row(cirp92_pkg::OpWrite, cirp92_pkg::PortFast,  8'h00, 1'b0, '0);
        add_row(cirp92_pkg::OpWrite, cirp92_pkg::PortFast,  8'h01, 1'b0, '0);
        add_row(cirp92_pkg::OpWrite, cirp92_pkg::PortFast,  8'hFE, 1'b0, '0);
        add_row(cirp92_pkg::OpWrite, cirp92_pkg::PortIndex, 8'hFF, 1'b0, '0);
        add_row(cirp92_pkg::OpWrite, cirp92_pkg::PortData,  8'hAA, 1'b0, '0);
        add_row(cirp92_pkg::OpRead,  cirp92_pkg::PortData,  8'h00, 1'b0, '0);
        add_row(cirp92_pkg::OpRead,  cirp92_pkg::PortIndex, 8'h00, 1'b0, '0);
        add_row(cirp92_pkg::OpWrite, cirp92_pkg::PortIndex, 8'h00, 1'b0, '0);
        add_row(cirp92_pkg::OpRead,  cirp92_pkg::PortData,  8'h00, 1'b0, '0);
        for (int i = 0; i < RandItems; i++) add_random_row();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted < access_q.size() || pending_results.size() != 0) @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);

        if (errors == 0 && pending_results.size() == 0) begin
            $display("chipset_index_regs_shadow_port92_top verification clean");
        end else begin
            $display("chipset_index_regs_shadow_port92_top verification failed");
        end
        $finish;
    end

endmodule
